// ===== rtl/core/ndefp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// NDEF record parser package
// Section codes, flag byte bit positions and the result record shared by the
// parser core and the top level.
// ----------------------------------------------------------------------------
package ndefp_pkg;

  // Section codes; the parser phase uses the same encoding.
  localparam logic [2:0] SEC_FLAG    = 3'd0;
  localparam logic [2:0] SEC_TLEN    = 3'd1;
  localparam logic [2:0] SEC_PLEN    = 3'd2;
  localparam logic [2:0] SEC_IDLEN   = 3'd3;
  localparam logic [2:0] SEC_TYPE    = 3'd4;
  localparam logic [2:0] SEC_ID      = 3'd5;
  localparam logic [2:0] SEC_PAYLOAD = 3'd6;

  // Bit positions within the flag byte.
  localparam int FLG_MB_BIT = 7;
  localparam int FLG_ME_BIT = 6;
  localparam int FLG_CF_BIT = 5;
  localparam int FLG_SR_BIT = 4;
  localparam int FLG_IL_BIT = 3;

  // Index of the last long payload length byte.
  localparam logic [1:0] LEN_BYTE_LAST = 2'd3;

  // One result request.
  typedef struct packed {
    logic [7:0]  data_out;
    logic [2:0]  section;
    logic [2:0]  tnf;
    logic        message_begin;
    logic        message_end;
    logic        chunk_flag;
    logic [7:0]  type_length;
    logic [7:0]  id_length;
    logic [31:0] payload_length;
    logic        record_end;
    logic        empty_payload_error;
  } result_t;

endpackage

// ===== rtl/core/ndefp_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// NDEF record parser core
// Holds the record state and works out combinationally, for one byte, the
// section tag, the decoded header fields and the record end marker.
// ----------------------------------------------------------------------------
module ndefp_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                step,
  input  logic [7:0]          data_byte,
  input  logic                start_record,
  input  logic                reject_empty,
  output ndefp_pkg::result_t  result
);

  logic [2:0]  phase_r, phase_nxt;
  logic [7:0]  flag_r, flag_nxt;
  logic [7:0]  tlen_r, tlen_nxt;
  logic [7:0]  idlen_r, idlen_nxt;
  logic [31:0] plen_r, plen_nxt;
  logic [1:0]  lcnt_r, lcnt_nxt;
  logic [31:0] rem_r, rem_nxt;
  logic [2:0]  cur;
  logic        rec_end;
  logic        rem_last;

  // The counter reaches zero on this byte when it holds one now.
  assign rem_last = (rem_r == 32'd1);

  // Next state and record end for the current byte.
  always_comb begin
    phase_nxt = phase_r;
    flag_nxt  = flag_r;
    tlen_nxt  = tlen_r;
    idlen_nxt = idlen_r;
    plen_nxt  = plen_r;
    lcnt_nxt  = lcnt_r;
    rem_nxt   = rem_r;
    rec_end   = 1'b0;

    cur = start_record ? ndefp_pkg::SEC_FLAG : phase_r;
    if (cur > ndefp_pkg::SEC_PAYLOAD) begin
      cur = ndefp_pkg::SEC_FLAG;
    end

    case (cur)
      ndefp_pkg::SEC_FLAG: begin
        flag_nxt  = data_byte;
        tlen_nxt  = 8'd0;
        idlen_nxt = 8'd0;
        plen_nxt  = 32'd0;
        lcnt_nxt  = 2'd0;
        rem_nxt   = 32'd0;
        phase_nxt = ndefp_pkg::SEC_TLEN;
      end
      ndefp_pkg::SEC_TLEN: begin
        tlen_nxt  = data_byte;
        lcnt_nxt  = 2'd0;
        phase_nxt = ndefp_pkg::SEC_PLEN;
      end
      ndefp_pkg::SEC_PLEN: begin
        if (flag_r[ndefp_pkg::FLG_SR_BIT] || (lcnt_r == ndefp_pkg::LEN_BYTE_LAST)) begin
          // Last length byte: move on to the ID length or the body, or end the record.
          plen_nxt = flag_r[ndefp_pkg::FLG_SR_BIT] ? {24'd0, data_byte}
                                                   : {plen_r[23:0], data_byte};
          lcnt_nxt = 2'd0;
          if (flag_r[ndefp_pkg::FLG_IL_BIT]) begin
            phase_nxt = ndefp_pkg::SEC_IDLEN;
          end else if (tlen_r != 8'd0) begin
            phase_nxt = ndefp_pkg::SEC_TYPE;
            rem_nxt   = {24'd0, tlen_r};
          end else if (idlen_r != 8'd0) begin
            phase_nxt = ndefp_pkg::SEC_ID;
            rem_nxt   = {24'd0, idlen_r};
          end else if (plen_nxt != 32'd0) begin
            phase_nxt = ndefp_pkg::SEC_PAYLOAD;
            rem_nxt   = plen_nxt;
          end else begin
            phase_nxt = ndefp_pkg::SEC_FLAG;
            rec_end   = 1'b1;
          end
        end else begin
          plen_nxt = {plen_r[23:0], data_byte};
          lcnt_nxt = lcnt_r + 2'd1;
        end
      end
      ndefp_pkg::SEC_IDLEN: begin
        idlen_nxt = data_byte;
        if (tlen_r != 8'd0) begin
          phase_nxt = ndefp_pkg::SEC_TYPE;
          rem_nxt   = {24'd0, tlen_r};
        end else if (data_byte != 8'd0) begin
          phase_nxt = ndefp_pkg::SEC_ID;
          rem_nxt   = {24'd0, data_byte};
        end else if (plen_r != 32'd0) begin
          phase_nxt = ndefp_pkg::SEC_PAYLOAD;
          rem_nxt   = plen_r;
        end else begin
          phase_nxt = ndefp_pkg::SEC_FLAG;
          rec_end   = 1'b1;
        end
      end
      ndefp_pkg::SEC_TYPE: begin
        rem_nxt = rem_r - 32'd1;
        if (rem_last) begin
          if (idlen_r != 8'd0) begin
            phase_nxt = ndefp_pkg::SEC_ID;
            rem_nxt   = {24'd0, idlen_r};
          end else if (plen_r != 32'd0) begin
            phase_nxt = ndefp_pkg::SEC_PAYLOAD;
            rem_nxt   = plen_r;
          end else begin
            phase_nxt = ndefp_pkg::SEC_FLAG;
            rec_end   = 1'b1;
          end
        end
      end
      ndefp_pkg::SEC_ID: begin
        rem_nxt = rem_r - 32'd1;
        if (rem_last) begin
          if (plen_r != 32'd0) begin
            phase_nxt = ndefp_pkg::SEC_PAYLOAD;
            rem_nxt   = plen_r;
          end else begin
            phase_nxt = ndefp_pkg::SEC_FLAG;
            rec_end   = 1'b1;
          end
        end
      end
      default: begin
        // Payload bytes: count down to the end of the record.
        rem_nxt = rem_r - 32'd1;
        if (rem_last) begin
          phase_nxt = ndefp_pkg::SEC_FLAG;
          rec_end   = 1'b1;
        end
      end
    endcase
  end

  // Result fields are taken from the state as it stands after this byte.
  always_comb begin
    result.data_out            = data_byte;
    result.section             = cur;
    result.tnf                 = flag_nxt[2:0];
    result.message_begin       = flag_nxt[ndefp_pkg::FLG_MB_BIT];
    result.message_end         = flag_nxt[ndefp_pkg::FLG_ME_BIT];
    result.chunk_flag          = flag_nxt[ndefp_pkg::FLG_CF_BIT];
    result.type_length         = tlen_nxt;
    result.id_length           = idlen_nxt;
    result.payload_length      = plen_nxt;
    result.record_end          = rec_end;
    result.empty_payload_error = rec_end && (plen_nxt == 32'd0) && reject_empty;
  end

  // Record state registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= ndefp_pkg::SEC_FLAG;
      flag_r  <= 8'd0;
      tlen_r  <= 8'd0;
      idlen_r <= 8'd0;
      plen_r  <= 32'd0;
      lcnt_r  <= 2'd0;
      rem_r   <= 32'd0;
    end else if (step) begin
      phase_r <= phase_nxt;
      flag_r  <= flag_nxt;
      tlen_r  <= tlen_nxt;
      idlen_r <= idlen_nxt;
      plen_r  <= plen_nxt;
      lcnt_r  <= lcnt_nxt;
      rem_r   <= rem_nxt;
    end
  end

endmodule

// ===== rtl/core/ndef_record_parser.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// NDEF record parser
// Tags each byte of an NDEF record stream with its section and the decoded
// header fields, and marks the last byte of each record.
// ----------------------------------------------------------------------------
// The parser takes one byte per clock cycle while the output side does not
// stall and returns one result request per byte, in order. A byte is held in
// the input register, decoded against the record state, and the result lands
// in the output register, from which it is offered. The update of the record
// state (phase, the header lengths and the 32-bit down-counter) for each byte
// sets the throughput of one byte per cycle. The input register keeps taking
// bytes while a result waits in the output register; stall on the input side
// rises only when both hold a request. The reject_empty_payload register
// resets to one and is written through the cfg_ channel, which is always
// ready; write it only while no request is in flight, since a byte already
// held in the input register is decoded with the new value.
module ndef_record_parser (
  input  logic        clk,
  input  logic        rst_n,
  // Input channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_data_byte,
  input  logic        in_start_record,
  // Result channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_data_out,
  output logic [2:0]  out_section,
  output logic [2:0]  out_tnf,
  output logic        out_message_begin,
  output logic        out_message_end,
  output logic        out_chunk_flag,
  output logic [7:0]  out_type_length,
  output logic [7:0]  out_id_length,
  output logic [31:0] out_payload_length,
  output logic        out_record_end,
  output logic        out_empty_payload_error,
  // Configuration channel
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_reject_empty_payload
);

  logic               in_valid_r, in_valid_nxt;
  logic [7:0]         in_data_r;
  logic               in_start_r;
  logic               out_valid_r, out_valid_nxt;
  ndefp_pkg::result_t res_r;
  ndefp_pkg::result_t res_nxt;
  logic               reject_r;
  logic               out_load;
  logic               step;
  logic               in_take;

  // Handshake control between the two registers.
  assign out_load = !out_valid_r || !out_stall;
  assign step     = in_valid_r && out_load;
  assign in_stall = in_valid_r && !out_load;
  assign in_take  = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  always_comb begin
    in_valid_nxt = in_valid_r;
    if (in_take) begin
      in_valid_nxt = 1'b1;
    end else if (step) begin
      in_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (step) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      reject_r    <= 1'b1;
    end else begin
      in_valid_r  <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        reject_r <= cfg_reject_empty_payload;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (in_take) begin
      in_data_r  <= in_data_byte;
      in_start_r <= in_start_record;
    end
    if (step) begin
      res_r <= res_nxt;
    end
  end

  // Per-byte decode and record state.
  ndefp_core u_core (
    .clk          (clk),
    .rst_n        (rst_n),
    .step         (step),
    .data_byte    (in_data_r),
    .start_record (in_start_r),
    .reject_empty (reject_r),
    .result       (res_nxt)
  );

  // Result outputs.
  assign out_valid               = out_valid_r;
  assign out_data_out            = res_r.data_out;
  assign out_section             = res_r.section;
  assign out_tnf                 = res_r.tnf;
  assign out_message_begin       = res_r.message_begin;
  assign out_message_end         = res_r.message_end;
  assign out_chunk_flag          = res_r.chunk_flag;
  assign out_type_length         = res_r.type_length;
  assign out_id_length           = res_r.id_length;
  assign out_payload_length      = res_r.payload_length;
  assign out_record_end          = res_r.record_end;
  assign out_empty_payload_error = res_r.empty_payload_error;

endmodule
